>>> rtl/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Types, sizes and codes shared by the slab slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // slab geometry
    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int WORD_BITS = 32;
    localparam int WBIT_W    = $clog2(WORD_BITS);
    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int VISIT_W   = $clog2(NUM_WORDS + 1);

    // register and field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 13;
    localparam int OIU_W  = 9;
    localparam int LIM_W  = CNT_W + SIZE_W;
    localparam int PROD_W = SLOT_W + SIZE_W;
    localparam int STEP_W = $clog2(SLOT_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0] OBJ_SIZE_RST = SIZE_W'(16);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_BASE      = 2'd0,
        CFG_OBJECT_SIZE    = 2'd1,
        CFG_OBJECTS_IN_USE = 2'd2
    } t_cfg_idx;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FILL_EMPTY   = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_FULL    = 2'd2
    } t_fill;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_MUL,
        S_FLIM,
        S_FCHK,
        S_FDIV,
        S_FBIT,
        S_FIN
    } t_state;

    // bitmap memory access
    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } t_map_req;

    // divider result
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] quot;
        logic              rem_zero;
    } t_div_rsp;

endpackage

>>> rtl/bsa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_req_if
// Request channel: allocate or free, with the address to free.
// ----------------------------------------------------------------------------
interface bsa_req_if
    import bsa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, output kind, output free_addr, input ready);
    modport sink   (input valid, input kind, input free_addr, output ready);
endinterface

>>> rtl/bsa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Response channel: one beat per request.
// ----------------------------------------------------------------------------
interface bsa_rsp_if
    import bsa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] object_addr;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  used_now;
    logic [1:0]        fill;

    modport source (output valid, output status, output object_addr, output slot,
                    output used_now, output fill, input ready);
    modport sink   (input valid, input status, input object_addr, input slot,
                    input used_now, input fill, output ready);
endinterface

>>> rtl/bsa_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_bitmap
// Used bitmap of the slab, one word of slots per entry, registered read.
// ----------------------------------------------------------------------------
module bsa_bitmap
    import bsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_map_req             i_req,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic [NUM_WORDS-1:0] r_wvld;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // a word never written since reset reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_wvld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_wvld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

>>> rtl/bsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_div
// Restoring divider, one quotient bit per cycle, quotient below MAX_SLOTS.
// ----------------------------------------------------------------------------
module bsa_div
    import bsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LIM_W-1:0]  i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output t_div_rsp          o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [LIM_W-1:0]  r_rem;
    logic [LIM_W-1:0]  r_dsr;
    logic [SLOT_W-1:0] r_quot;
    logic              ge;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SLOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend is known to be below divisor * MAX_SLOTS
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_dsr  <= LIM_W'(i_divisor) << (SLOT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quot <= {r_quot[SLOT_W-2:0], ge};
            r_dsr  <= r_dsr >> 1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quot     = r_quot;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

>>> rtl/bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Slab slot allocator over a used bitmap held in a word-wide memory.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (kind 0 allocate, kind 1 free with free_addr) and
// each one gives exactly one beat on o_rsp. The user must write configuration
// (data base, object size, slot count) through i_cfg_we / i_cfg_idx /
// i_cfg_data while no request is in flight; the block does not enforce this.
// One request is worked at a time. An allocate walks the bitmap one 32-slot
// word at a time (read, then scan), starting at the hint word, for at most
// NUM_WORDS + 1 words; once a free slot is found the word is written back
// and the object address is multiplied out; with no free slot it answers full.
// A free checks the address range, runs the serial divider (one quotient
// bit per cycle) and one read-modify-write of the bitmap word; an address
// out of range answers after the range check, a misaligned one after the
// divider. The next request is accepted in the cycle after the result loads.
// Reset clears the fill count, hints and per-word valid flags at once; no
// clearing pass is needed and a request can be accepted right after reset.
// The result waits in an output register; while the receiver stalls it the
// next request is still accepted and worked, and holds only at its own
// result until the register drains.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsa_req_if.sink               i_req,
    bsa_rsp_if.source             o_rsp
);

    // configuration
    logic [ADDR_W-1:0] r_data_base;
    logic [SIZE_W-1:0] r_obj_size;
    logic [OIU_W-1:0]  r_obj_cnt;

    // control
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_used;
    logic              r_la_vld;
    logic              r_lf_vld;
    logic              r_o_vld;

    // request context
    logic [ADDR_W-1:0] r_addr;
    logic [WADDR_W-1:0] r_wrd;
    logic [WBIT_W-1:0] r_hint_b;
    logic [VISIT_W-1:0] r_visit;
    logic [SLOT_W-1:0] r_slot;
    t_status           r_status;
    logic              r_alloc_ok;
    logic [PROD_W-1:0] r_prod;
    logic [LIM_W-1:0]  r_lim;
    logic [ADDR_W-1:0] r_off;
    logic              r_below;
    logic [SLOT_W-1:0] r_la_slot;
    logic [SLOT_W-1:0] r_lf_slot;

    // output register
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_addr;
    logic [SLOT_W-1:0] r_o_slot;
    logic [CNT_W-1:0]  r_o_used;
    t_fill             r_o_fill;

    logic [CNT_W-1:0]     slot_lim;
    logic [SIZE_W-1:0]    size_eff;
    logic [CNT_W-1:0]     hint;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] avail;
    logic [WBIT_W-1:0]    enc;
    logic                 found;
    logic                 bit_used;
    logic                 bad_range;
    logic                 last_visit;
    logic                 accept;
    logic                 out_load;
    logic                 div_start;
    t_map_req             map_req;
    t_div_rsp             div_rsp;
    t_fill                fill_now;

    assign slot_lim = (r_obj_cnt > OIU_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_obj_cnt);
    assign size_eff = (r_obj_size == '0) ? SIZE_W'(1) : r_obj_size;

    // next-fit start: last freed, else after last allocated, else zero; zero also at or past the slot limit
    always_comb begin
        if (r_lf_vld) begin
            hint = CNT_W'(r_lf_slot);
        end else if (r_la_vld) begin
            hint = CNT_W'(r_la_slot) + 1'b1;
        end else begin
            hint = '0;
        end
        if (hint >= slot_lim) begin
            hint = '0;
        end
    end

    assign accept     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign last_visit = (r_visit == VISIT_W'(NUM_WORDS));

    // free slots of the current word: first visit from the hint bit up,
    // the wrap-around visit of the same word below it
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = !rd_data[b] && (CNT_W'({r_wrd, WBIT_W'(b)}) < slot_lim);
            if (r_visit == '0) begin
                avail[b] = avail[b] && (WBIT_W'(b) >= r_hint_b);
            end else if (last_visit) begin
                avail[b] = avail[b] && (WBIT_W'(b) < r_hint_b);
            end
        end
        enc = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                enc = WBIT_W'(b);
            end
        end
    end

    assign found     = |avail;
    assign bit_used  = rd_data[r_slot[WBIT_W-1:0]];
    assign bad_range = r_below || (r_off >= ADDR_W'(r_lim));
    assign out_load  = (r_state == S_FIN) && (!r_o_vld || o_rsp.ready);

    always_comb begin
        if (r_used == '0) begin
            fill_now = FILL_EMPTY;
        end else if (r_used >= slot_lim) begin
            fill_now = FILL_FULL;
        end else begin
            fill_now = FILL_PARTIAL;
        end
    end

    // next state and memory/divider controls
    always_comb begin
        n_state         = r_state;
        map_req         = '0;
        div_start       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.kind == KIND_ALLOC) ? S_RD : S_FLIM;
                end
            end
            S_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = r_wrd;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                if (found) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = r_wrd;
                    map_req.wr_data = rd_data | (WORD_BITS'(1) << enc);
                    n_state         = S_MUL;
                end else if (last_visit) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_FLIM: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (bad_range) begin
                    n_state = S_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_FDIV;
                end
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = div_rsp.quot[SLOT_W-1:WBIT_W];
                        n_state         = S_FBIT;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FBIT: begin
                if (bit_used) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = r_slot[SLOT_W-1:WBIT_W];
                    map_req.wr_data = rd_data & ~(WORD_BITS'(1) << r_slot[WBIT_W-1:0]);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_o_vld || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base <= '0;
            r_obj_size  <= OBJ_SIZE_RST;
            r_obj_cnt   <= OIU_W'(MAX_SLOTS);
            r_used      <= '0;
            r_la_vld    <= 1'b0;
            r_lf_vld    <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DATA_BASE:      r_data_base <= i_cfg_data[ADDR_W-1:0];
                    CFG_OBJECT_SIZE:    r_obj_size  <= i_cfg_data[SIZE_W-1:0];
                    CFG_OBJECTS_IN_USE: r_obj_cnt   <= i_cfg_data[OIU_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_SCAN && found) begin
                r_used   <= r_used + 1'b1;
                r_la_vld <= 1'b1;
                r_lf_vld <= 1'b0;
            end
            if (r_state == S_FBIT && bit_used) begin
                if (r_used != '0) begin
                    r_used <= r_used - 1'b1;
                end
                r_lf_vld <= 1'b1;
            end
            if (out_load) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= i_req.free_addr;
            r_wrd      <= hint[SLOT_W-1:WBIT_W];
            r_hint_b   <= hint[WBIT_W-1:0];
            r_visit    <= '0;
            r_slot     <= '0;
            r_status   <= ST_OK;
            r_alloc_ok <= 1'b0;
        end
        case (r_state)
            S_SCAN: begin
                if (found) begin
                    r_slot     <= {r_wrd, enc};
                    r_la_slot  <= {r_wrd, enc};
                    r_alloc_ok <= 1'b1;
                end else if (last_visit) begin
                    r_status <= ST_FULL;
                end else begin
                    r_wrd   <= r_wrd + 1'b1;
                    r_visit <= r_visit + 1'b1;
                end
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_slot) * PROD_W'(size_eff);
            end
            S_FLIM: begin
                r_lim   <= LIM_W'(slot_lim) * LIM_W'(size_eff);
                r_off   <= r_addr - r_data_base;
                r_below <= (r_addr < r_data_base);
            end
            S_FCHK: begin
                if (bad_range) begin
                    r_status <= ST_BAD_ADDR;
                end
            end
            S_FDIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem_zero) begin
                        r_slot <= div_rsp.quot;
                    end else begin
                        r_status <= ST_BAD_ADDR;
                    end
                end
            end
            S_FBIT: begin
                if (bit_used) begin
                    r_lf_slot <= r_slot;
                end else begin
                    r_status <= ST_NOT_USED;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_status <= r_status;
            r_o_addr   <= r_alloc_ok ? (r_data_base + ADDR_W'(r_prod)) : '0;
            r_o_slot   <= r_slot;
            r_o_used   <= r_used;
            r_o_fill   <= fill_now;
        end
    end

    bsa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (rd_data)
    );

    bsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_off[LIM_W-1:0]),
        .i_divisor  (size_eff),
        .o_rsp      (div_rsp)
    );

    assign o_rsp.valid       = r_o_vld;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.object_addr = r_o_addr;
    assign o_rsp.slot        = r_o_slot;
    assign o_rsp.used_now    = r_o_used;
    assign o_rsp.fill        = r_o_fill;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_SLOTS))
        else $error("used count above slab capacity");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && found) |=> (r_used == $past(r_used) + 1'b1))
        else $error("allocation did not bump used count");

    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |->
            (o_rsp.object_addr == '0 && o_rsp.slot == '0))
        else $error("full response carries an address or slot");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fill == FILL_EMPTY) |-> (o_rsp.used_now == '0))
        else $error("empty fill with slots in use");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_FDIV))
        else $error("divider finished outside a free");
`endif

endmodule
